// ----- hdl/assert_macros.svh -----
// Assertion macros used by the deque top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hdl/deq_pkg.sv -----
// Package with the types and constants shared by the deque modules.
`default_nettype none
package deq_pkg;

  localparam int unsigned DepthDefault     = 1024;
  localparam int unsigned WordWidthDefault = 32;
  localparam int unsigned CountW           = 11;
  localparam int unsigned ValueW           = 32;

  typedef enum logic [2:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_PEEK_FRONT = 3'd4,
    FN_PEEK_BACK  = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]               func;
    logic signed [ValueW-1:0] value_in;
  } in_word_t;

  typedef struct packed {
    logic signed [ValueW-1:0] value_out;
    logic [1:0]               status;
    logic [CountW-1:0]        count;
    logic                     is_empty;
  } out_word_t;

  typedef struct packed {
    logic accept;
    logic load_out;
  } ctrl_cmd_t;

endpackage
`default_nettype wire

// ----- hdl/deq_ctrl.sv -----
// Controller state machine of the deque: input handshake, sequencing and output valid.
`default_nettype none
module deq_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  wire              out_stall_i,
  output deq_pkg::ctrl_cmd_t cmd_o
);
  import deq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept, load;

  assign in_stall_o   = (state_q != S_IDLE);
  assign accept       = in_valid_i && (state_q == S_IDLE);
  assign load         = (state_q == S_READ) && (!out_valid_q || !out_stall_i);
  assign cmd_o.accept   = accept;
  assign cmd_o.load_out = load;
  assign out_valid_o  = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_READ;
      end
      S_READ: begin
        if (load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = load ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/deq_datapath.sv -----
// Datapath of the deque: ring store, head and count registers and result register.
`default_nettype none
module deq_datapath #(
  parameter int unsigned DEPTH      = deq_pkg::DepthDefault,
  parameter int unsigned WORD_WIDTH = deq_pkg::WordWidthDefault
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  deq_pkg::ctrl_cmd_t  cmd_i,
  input  deq_pkg::in_word_t   in_word_i,
  output deq_pkg::out_word_t  out_word_o
);
  import deq_pkg::*;

  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned SW    = AW + 1;
  localparam int unsigned EXT_W = (WORD_WIDTH > ValueW) ? WORD_WIDTH : ValueW;

  logic [WORD_WIDTH-1:0] mem [DEPTH];

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] res_count_q;
  logic [1:0]    res_status_q;
  logic          res_read_q;
  logic [WORD_WIDTH-1:0] rd_q;
  out_word_t     out_q;

  logic [SW-1:0] sum_raw, last_raw, sum_wrap, last_wrap;
  logic [AW-1:0] head_next, head_prev, wr_addr, rd_addr;
  logic          wr_en, rd_flag, full, empty;
  status_e       status_d;
  logic signed [EXT_W-1:0] in_ext, rd_ext;
  logic [WORD_WIDTH-1:0]   wr_word;

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  assign sum_raw   = SW'(head_q) + SW'(count_q);
  assign last_raw  = sum_raw - SW'(1);
  assign sum_wrap  = (sum_raw >= SW'(DEPTH)) ? sum_raw - SW'(DEPTH) : sum_raw;
  assign last_wrap = (last_raw >= SW'(DEPTH)) ? last_raw - SW'(DEPTH) : last_raw;

  assign head_next = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
  assign head_prev = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);

  assign in_ext  = EXT_W'($signed(in_word_i.value_in));
  assign wr_word = in_ext[WORD_WIDTH-1:0];
  assign rd_ext  = EXT_W'($signed(rd_q));

  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    wr_en    = 1'b0;
    wr_addr  = sum_wrap[AW-1:0];
    rd_addr  = head_q;
    rd_flag  = 1'b0;
    status_d = ST_OK;
    unique case (in_word_i.func)
      FN_PUSH_FRONT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          head_d  = head_prev;
          wr_addr = head_prev;
          wr_en   = 1'b1;
          count_d = count_q + CW'(1);
        end
      end
      FN_PUSH_BACK: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + CW'(1);
        end
      end
      FN_POP_FRONT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          rd_flag = 1'b1;
          head_d  = head_next;
          count_d = count_q - CW'(1);
        end
      end
      FN_POP_BACK: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          rd_addr = last_wrap[AW-1:0];
          rd_flag = 1'b1;
          count_d = count_q - CW'(1);
        end
      end
      FN_PEEK_FRONT: begin
        if (empty) status_d = ST_EMPTY;
        else rd_flag = 1'b1;
      end
      FN_PEEK_BACK: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          rd_addr = last_wrap[AW-1:0];
          rd_flag = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && wr_en) mem[wr_addr] <= wr_word;
    if (cmd_i.accept) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.accept) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      res_count_q  <= count_d;
      res_status_q <= status_d;
      res_read_q   <= rd_flag;
    end
    if (cmd_i.load_out) begin
      out_q.value_out <= res_read_q ? rd_ext[ValueW-1:0] : '0;
      out_q.status    <= res_status_q;
      out_q.count     <= CountW'(res_count_q);
      out_q.is_empty  <= (res_count_q == '0);
    end
  end

  assign out_word_o = out_q;

endmodule
`default_nettype wire

// ----- hdl/double_ended_queue_core.sv -----
// Top level of the double-ended queue: controller, datapath and assertions.
//
// Usage: each input word on in_word_i carries an operation code (push front,
// push back, pop front, pop back, peek front, peek back) and a value that only
// pushes use. A word is taken when in_valid_i is high and in_stall_o is low.
// Every input word gives exactly one result word on out_word_o, qualified by
// out_valid_o and taken when out_stall_i is low.
// The result appears after the input is taken: the ring store is read into
// its read register, then the output register is loaded. The block takes no
// new word until the result of the last one is loaded into the output
// register.
// While a result waits in the output register, the next word is still taken
// and its store access done; it then waits until the output register frees.
// Reset empties the deque: head and count go to zero and no result is valid.
// The store itself is not cleared, since only held entries ever reach value_out.
`default_nettype none
`include "assert_macros.svh"
module double_ended_queue_core #(
  parameter int unsigned DEPTH      = deq_pkg::DepthDefault,
  parameter int unsigned WORD_WIDTH = deq_pkg::WordWidthDefault
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  deq_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output deq_pkg::out_word_t out_word_o
);
  import deq_pkg::*;

  ctrl_cmd_t cmd;

  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  deq_datapath #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_word_i  (in_word_i),
    .out_word_o (out_word_o)
  );

  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, cmd.accept, in_stall_o)
  `ASSERT_IMPLY(a_full_reads_zero, clk_i, rst_ni, out_valid_o && (out_word_o.status == ST_FULL), out_word_o.value_out == '0)
  `ASSERT_IMPLY(a_empty_flag, clk_i, rst_ni, out_valid_o, out_word_o.is_empty == (out_word_o.count == '0))
  `ASSERT_IMPLY(a_empty_status_count, clk_i, rst_ni, out_valid_o && (out_word_o.status == ST_EMPTY), out_word_o.is_empty)

endmodule
`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for the double-ended queue core with a built-in deque predictor.
module tb;
  import deq_pkg::*;

  localparam int unsigned Depth       = DepthDefault;
  localparam logic [2:0]  FnNopLow    = 3'd6;
  localparam logic [2:0]  FnNopHigh   = 3'd7;
  localparam int          RandomWords = 1900;

  logic      clk       = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  double_ended_queue_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  in_word_t    stim_q[$];
  out_word_t   expect_q[$];
  out_word_t   exp_w;
  int          presented   = 0;
  int          accepted    = 0;
  int          errors      = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          fill_level  = 0;

  logic [31:0] ring_mem [Depth];
  int          ring_head  = 0;
  int          ring_count = 0;

  function automatic out_word_t deque_apply(in_word_t w);
    out_word_t r;
    int        pos;
    r        = '0;
    r.status = ST_OK;
    case (w.func)
      FN_PUSH_FRONT, FN_PUSH_BACK: begin
        if (ring_count >= Depth) begin
          r.status = ST_FULL;
        end else begin
          if (w.func == FN_PUSH_FRONT) begin
            ring_head = (ring_head + Depth - 1) % Depth;
            pos       = ring_head;
          end else begin
            pos = (ring_head + ring_count) % Depth;
          end
          ring_mem[pos] = w.value_in;
          ring_count++;
        end
      end
      FN_POP_FRONT, FN_POP_BACK, FN_PEEK_FRONT, FN_PEEK_BACK: begin
        if (ring_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (w.func == FN_POP_FRONT || w.func == FN_PEEK_FRONT) begin
            pos = ring_head;
          end else begin
            pos = (ring_head + ring_count - 1) % Depth;
          end
          r.value_out = ring_mem[pos];
          if (w.func == FN_POP_FRONT) begin
            ring_head = (ring_head + 1) % Depth;
            ring_count--;
          end else if (w.func == FN_POP_BACK) begin
            ring_count--;
          end
        end
      end
      default: begin
      end
    endcase
    r.count    = ring_count[CountW-1:0];
    r.is_empty = (ring_count == 0);
    return r;
  endfunction

  task automatic add_word(logic [2:0] f, logic [31:0] v);
    in_word_t w;
    w.func     = f;
    w.value_in = v;
    stim_q.insert(stim_q.size(), w);
    if (f == FN_PUSH_FRONT || f == FN_PUSH_BACK) begin
      if (fill_level < Depth) fill_level++;
    end else if (f == FN_POP_FRONT || f == FN_POP_BACK) begin
      if (fill_level > 0) fill_level--;
    end
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    v = $urandom;
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: v = 32'h7fff_ffff;
        1: v = 32'h8000_0000;
        2: v = 32'h0000_0000;
        default: v = 32'hffff_ffff;
      endcase
    end
    return v;
  endfunction

  function automatic logic [2:0] pick_func(int push_pct, int read_pct);
    int r;
    r = $urandom_range(99);
    if (r < push_pct) return $urandom_range(1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
    if (r < push_pct + read_pct) return 3'(FN_POP_FRONT + $urandom_range(3));
    return $urandom_range(1) ? FnNopHigh : FnNopLow;
  endfunction

  initial begin
    forever #2 clk = ~clk;
  end

  always @(negedge clk) begin
    case (presented * 3 / (stim_q.size() + 1))
      0: begin
        tx_idle_pct = 21;
        rx_idle_pct = 49;
      end
      1: begin
        tx_idle_pct = 49;
        rx_idle_pct = 21;
      end
      default: begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
    endcase
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (in_valid && accepted < presented) begin
    end else if (presented < stim_q.size() && $urandom_range(99) >= tx_idle_pct) begin
      in_word  <= stim_q[presented];
      in_valid <= 1'b1;
      presented++;
    end else begin
      in_valid <= 1'b0;
    end
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        expect_q.insert(expect_q.size(), deque_apply(in_word));
        accepted++;
      end
      if (out_valid && !out_stall) begin
        if (expect_q.size() == 0) begin
          $error("result word with no expectation waiting");
          errors++;
        end else begin
          exp_w = expect_q[0];
          expect_q.delete(0);
          if (out_word.value_out !== exp_w.value_out) begin
            $error("value_out: expected %0d, got %0d", exp_w.value_out, out_word.value_out);
            errors++;
          end
          if (out_word.status !== exp_w.status) begin
            $error("status: expected %0d, got %0d", exp_w.status, out_word.status);
            errors++;
          end
          if (out_word.count !== exp_w.count) begin
            $error("count: expected %0d, got %0d", exp_w.count, out_word.count);
            errors++;
          end
          if (out_word.is_empty !== exp_w.is_empty) begin
            $error("is_empty: expected %0d, got %0d", exp_w.is_empty, out_word.is_empty);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    int made;
    int stage;
    int stage_len;
    add_word(FN_POP_FRONT, 32'h1234_5678);
    add_word(FN_POP_BACK, 32'hffff_ffff);
    add_word(FN_PEEK_FRONT, 32'h0);
    add_word(FN_PEEK_BACK, 32'h8000_0000);
    add_word(FnNopLow, 32'h5555_5555);
    add_word(FnNopHigh, 32'haaaa_aaaa);
    add_word(FN_PUSH_BACK, 32'h7fff_ffff);
    add_word(FN_PUSH_FRONT, 32'h8000_0000);
    add_word(FN_PUSH_BACK, 32'hffff_ffff);
    add_word(FN_PUSH_FRONT, 32'h0000_0000);
    add_word(FN_PEEK_FRONT, 32'hdead_beef);
    add_word(FN_PEEK_BACK, 32'h0);
    add_word(FnNopHigh, 32'h0);
    add_word(FN_POP_BACK, 32'h0);
    add_word(FN_POP_FRONT, 32'h0);
    add_word(FN_PUSH_BACK, 32'h0000_0001);
    add_word(FN_POP_BACK, 32'h0);
    add_word(FN_POP_BACK, 32'h0);
    add_word(FN_POP_FRONT, 32'h0);
    add_word(FN_PEEK_BACK, 32'h0);
    add_word(FN_PUSH_FRONT, 32'h8000_0001);
    add_word(FN_POP_FRONT, 32'h0);

    // Mixed traffic, then fill to full, bounce at full, then drain.
    made      = 0;
    stage     = 0;
    stage_len = 0;
    while (made < RandomWords) begin
      case (stage)
        0: begin
          add_word(pick_func(45, 50), pick_value());
          if (++stage_len >= 150) begin
            stage     = 1;
            stage_len = 0;
          end
        end
        1: begin
          add_word(pick_func(90, 8), pick_value());
          if (fill_level >= Depth) stage = 2;
        end
        2: begin
          add_word(pick_func(50, 46), pick_value());
          if (++stage_len >= 60) stage = 3;
        end
        default: begin
          add_word(pick_func(8, 88), pick_value());
        end
      endcase
      made++;
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;
    while (accepted < stim_q.size()) @(posedge clk);
    while (expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/deq_pkg.sv
hdl/deq_ctrl.sv
hdl/deq_datapath.sv
hdl/double_ended_queue_core.sv
test/tb.sv
